// File: sv/brse_pkg.sv
// shared types and constants for the bitmap row span extractor
package brse_pkg;

  localparam int MAX_SPANS  = 5;
  localparam int SPAN_CNT_W = 3;
  localparam int LEFT_W     = 12;
  localparam int RIGHT_W    = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_W      = 13;
  localparam int BYTE_W     = 8;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [LEFT_W-1:0]  left;
    logic [RIGHT_W-1:0] right;
    logic [ROW_W-1:0]   row;
  } span_t;

endpackage

// File: sv/brse_span_calc.sv
// run detection over one byte of pixels: spans closed and next scan position
module brse_span_calc import brse_pkg::*; #(
  parameter int CW = 13,
  parameter int SW = 12,
  parameter int RW = 12
) (
  input  logic [BYTE_W-1:0]     pixel_byte,
  input  logic [CW-1:0]         col,
  input  logic [CW-1:0]         width,
  input  logic                  in_run,
  input  logic [SW-1:0]         run_start,
  input  logic [RW-1:0]         row,
  output span_t                 spans [MAX_SPANS],
  output logic [SPAN_CNT_W-1:0] span_cnt,
  output logic [CW-1:0]         col_next,
  output logic                  in_run_next,
  output logic [SW-1:0]         run_start_next,
  output logic                  row_end
);

  always_comb begin
    logic [CW:0]           room;
    logic [3:0]            adv;
    logic                  run;
    logic                  st_new;
    logic [2:0]            st_off;
    logic [SPAN_CNT_W-1:0] cnt;
    logic [CW:0]           sum;
    logic [31:0]           l32;
    logic [31:0]           r32;
    logic [31:0]           row32;
    logic                  pix;

    for (int i = 0; i < MAX_SPANS; i++) begin
      spans[i] = '0;
    end
    room   = (width > col) ? ({1'b0, width} - {1'b0, col}) : '0;
    adv    = (room > (CW+1)'(8)) ? 4'd8 : room[3:0];
    run    = in_run;
    st_new = 1'b0;
    st_off = '0;
    cnt    = '0;
    row32  = 32'(row);
    pix    = 1'b0;
    l32    = '0;
    r32    = '0;

    // columns past the row width are skipped
    for (int b = 0; b < BYTE_W; b++) begin
      if (4'(b) < adv) begin
        pix = pixel_byte[BYTE_W-1-b];
        if (pix && !run) begin
          run    = 1'b1;
          st_new = 1'b1;
          st_off = 3'(b);
        end else if (!pix && run) begin
          l32 = st_new ? (32'(col) + 32'(st_off)) : 32'(run_start);
          r32 = 32'(col) + 32'(b);
          if (cnt < SPAN_CNT_W'(MAX_SPANS)) begin
            spans[cnt] = '{left: l32[LEFT_W-1:0], right: r32[RIGHT_W-1:0],
                           row: row32[ROW_W-1:0]};
            cnt = cnt + 1'b1;
          end
          run = 1'b0;
        end
      end
    end

    sum     = {1'b0, col} + (CW+1)'(adv);
    row_end = (sum >= {1'b0, width});

    // run still open at the end of the row
    if (row_end && run) begin
      l32 = st_new ? (32'(col) + 32'(st_off)) : 32'(run_start);
      r32 = 32'(sum);
      if (cnt < SPAN_CNT_W'(MAX_SPANS)) begin
        spans[cnt] = '{left: l32[LEFT_W-1:0], right: r32[RIGHT_W-1:0],
                       row: row32[ROW_W-1:0]};
        cnt = cnt + 1'b1;
      end
    end

    l32            = 32'(col) + 32'(st_off);
    span_cnt       = cnt;
    col_next       = row_end ? '0 : sum[CW-1:0];
    in_run_next    = row_end ? 1'b0 : run;
    run_start_next = st_new ? l32[SW-1:0] : run_start;
  end

endmodule

// File: sv/bitmap_row_span_extractor_top.sv
// top level of the bitmap row span extractor
//
// pixel channel: one byte of a 1-bpp bitmap per transaction, bit 7 leftmost,
// rows padded to whole bytes. span channel: one run of set pixels per
// transaction (left column, exclusive right column, row), last_of_item
// marks the final span a byte produced. a byte with no runs produces nothing.
// the write port sets image_width (index 0) and image_height (index 1); the user
// must use it only while the block is idle, which the block itself does not enforce.
// an accepted byte is registered in the input register, and its spans then load
// the result buffer, whose head entry drives span_valid and the span ports.
// throughput: one byte per cycle while each byte closes at most one span and span_stall
// is low; after a byte closing n spans, the next byte with spans waits in the input
// register until the last of them leaves, as the single output port drains the
// five-entry result buffer.
// while span_stall is high the span on the ports holds, the buffer keeps the
// rest, and bytes that produce no span still go through.
// reset: column, row and run state clear, width and height return to 4096 (at most
// MAX_WIDTH, MAX_HEIGHT), both buffers empty; the block takes bytes the cycle after reset drops.
module bitmap_row_span_extractor_top import brse_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [CFG_W-1:0]   wr_data,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  logic [BYTE_W-1:0]  pixel_byte,
  output logic               span_valid,
  input  logic               span_stall,
  output logic [LEFT_W-1:0]  span_left,
  output logic [RIGHT_W-1:0] span_right,
  output logic [ROW_W-1:0]   span_row,
  output logic               last_of_item
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int SW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int W_RST = (4096 > MAX_WIDTH) ? MAX_WIDTH : 4096;
  localparam int H_RST = (4096 > MAX_HEIGHT) ? MAX_HEIGHT : 4096;

  logic [CW-1:0] width;
  logic [HW-1:0] height;
  logic [31:0]   wr_clamp_w;
  logic [31:0]   wr_clamp_h;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          in_run;
  logic [SW-1:0] run_start;

  logic               s1_valid;
  logic [BYTE_W-1:0]  s1_byte;

  span_t                 slots [MAX_SPANS];
  logic [SPAN_CNT_W-1:0] res_left;

  span_t                 calc_spans [MAX_SPANS];
  logic [SPAN_CNT_W-1:0] calc_cnt;
  logic [CW-1:0]         col_next;
  logic                  in_run_next;
  logic [SW-1:0]         run_start_next;
  logic                  row_end;
  logic [31:0]           row_inc;

  logic out_take;
  logic res_free;
  logic s1_move;

  // out-of-range settings act as the nearest legal value
  always_comb begin
    wr_clamp_w = (wr_data == '0) ? 32'd1 :
                 ((32'(wr_data) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(wr_data));
    wr_clamp_h = (wr_data == '0) ? 32'd1 :
                 ((32'(wr_data) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(wr_data));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= CW'(W_RST);
      height <= HW'(H_RST);
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_IMAGE_WIDTH:  width  <= wr_clamp_w[CW-1:0];
        REG_IMAGE_HEIGHT: height <= wr_clamp_h[HW-1:0];
        default: ;
      endcase
    end
  end

  brse_span_calc #(.CW(CW), .SW(SW), .RW(RW)) u_calc (
    .pixel_byte     (s1_byte),
    .col            (col),
    .width          (width),
    .in_run         (in_run),
    .run_start      (run_start),
    .row            (row),
    .spans          (calc_spans),
    .span_cnt       (calc_cnt),
    .col_next       (col_next),
    .in_run_next    (in_run_next),
    .run_start_next (run_start_next),
    .row_end        (row_end)
  );

  assign out_take    = span_valid && !span_stall;
  assign res_free    = (res_left == '0) || ((res_left == SPAN_CNT_W'(1)) && out_take);
  // bytes without spans never wait on the result buffer
  assign s1_move     = s1_valid && ((calc_cnt == '0) || res_free);
  assign pixel_stall = s1_valid && !s1_move;
  assign row_inc     = 32'(row) + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_valid && !pixel_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && !pixel_stall) begin
      s1_byte <= pixel_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      in_run    <= 1'b0;
      run_start <= '0;
    end else if (s1_move) begin
      col       <= col_next;
      in_run    <= in_run_next;
      run_start <= run_start_next;
      if (row_end) begin
        row <= (row_inc >= 32'(height)) ? '0 : row_inc[RW-1:0];
      end
    end
  end

  // result buffer: head entry drives the ports, shifts down on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      res_left <= '0;
    end else if (s1_move && (calc_cnt != '0)) begin
      res_left <= calc_cnt;
    end else if (out_take) begin
      res_left <= res_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && (calc_cnt != '0)) begin
      for (int i = 0; i < MAX_SPANS; i++) begin
        slots[i] <= calc_spans[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < MAX_SPANS - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

  assign span_valid   = (res_left != '0);
  assign span_left    = slots[0].left;
  assign span_right   = slots[0].right;
  assign span_row     = slots[0].row;
  assign last_of_item = (res_left == SPAN_CNT_W'(1));

endmodule

// File: sv/brse_checker.sv
// port-level checks for the bitmap row span extractor, bound to the top level
module brse_checker import brse_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               pixel_stall,
  input logic               span_valid,
  input logic               span_stall,
  input logic [LEFT_W-1:0]  span_left,
  input logic [RIGHT_W-1:0] span_right,
  input logic [ROW_W-1:0]   span_row,
  input logic               last_of_item
);

  // both sides come out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!span_valid && !pixel_stall))
    else $error("span output or input stall active after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (span_valid && span_stall) |=>
      (span_valid && $stable(span_left) && $stable(span_right) && $stable(span_row)
       && $stable(last_of_item)))
    else $error("stalled span transaction changed");

  // spans of one byte leave back to back
  a_burst: assert property (@(posedge clk) disable iff (rst)
    (span_valid && !span_stall && !last_of_item) |=> span_valid)
    else $error("gap inside the spans of one byte");

  a_same_row: assert property (@(posedge clk) disable iff (rst)
    (span_valid && !span_stall && !last_of_item) |=> (span_row == $past(span_row)))
    else $error("spans of one byte report different rows");

endmodule

bind bitmap_row_span_extractor_top brse_checker u_brse_checker (.*);

// File: verif/brse_span_checker.sv
// span checker: predicts the spans of each accepted pixel byte and compares them on the span channel
module brse_span_checker import brse_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [CFG_W-1:0]   wr_data,
  input  logic               pixel_valid,
  input  logic               pixel_stall,
  input  logic [BYTE_W-1:0]  pixel_byte,
  input  logic               span_valid,
  input  logic               span_stall,
  input  logic [LEFT_W-1:0]  span_left,
  input  logic [RIGHT_W-1:0] span_right,
  input  logic [ROW_W-1:0]   span_row,
  input  logic               last_of_item,
  output int                 mismatches,
  output int                 spans_pending,
  output int                 spans_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    span_t span;
    logic  last;
  } span_expect_t;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      run_start;
  logic             in_run;
  span_expect_t     expected_spans[$];

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void push_span(input int unsigned l, input int unsigned r,
                                    input int unsigned row);
    span_expect_t e;
    e.span.left  = l[LEFT_W-1:0];
    e.span.right = r[RIGHT_W-1:0];
    e.span.row   = row[ROW_W-1:0];
    e.last       = 1'b0;
    expected_spans.push_back(e);
  endfunction

  function automatic void predict_byte_spans(input logic [BYTE_W-1:0] px);
    int unsigned  w;
    int unsigned  h;
    int           first;
    logic         pix;
    span_expect_t e;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    first = expected_spans.size();
    for (int b = 0; b < BYTE_W; b++) begin
      // pixels at or past the width are dropped
      if (col_pos >= w) break;
      pix = px[BYTE_W-1-b];
      if (pix && !in_run) begin
        run_start = col_pos;
        in_run = 1'b1;
      end else if (!pix && in_run) begin
        push_span(run_start, col_pos, row_pos);
        in_run = 1'b0;
      end
      col_pos++;
    end
    // row end closes an open run at the current column
    if (col_pos >= w) begin
      if (in_run) push_span(run_start, col_pos, row_pos);
      in_run = 1'b0;
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end
    if (expected_spans.size() > first) begin
      e = expected_spans.pop_back();
      e.last = 1'b1;
      expected_spans.push_back(e);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] exp_val,
                                        input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  function automatic void check_span();
    span_expect_t e;
    if (expected_spans.size() == 0) begin
      $display("%0t: span left=%0d right=%0d row=%0d with none expected", $time,
               span_left, span_right, span_row);
      mismatches++;
    end else begin
      e = expected_spans.pop_front();
      spans_checked++;
      compare_field("span_left", 16'(e.span.left), 16'(span_left));
      compare_field("span_right", 16'(e.span.right), 16'(span_right));
      compare_field("span_row", 16'(e.span.row), 16'(span_row));
      compare_field("last_of_item", 16'(e.last), 16'(last_of_item));
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg     = CFG_W'(MAX_WIDTH);
      height_reg    = CFG_W'(MAX_HEIGHT);
      col_pos       = 0;
      row_pos       = 0;
      run_start     = 0;
      in_run        = 1'b0;
      mismatches    = 0;
      spans_checked = 0;
      expected_spans.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_IMAGE_WIDTH:  width_reg = wr_data;
          REG_IMAGE_HEIGHT: height_reg = wr_data;
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) predict_byte_spans(pixel_byte);
      if (span_valid && !span_stall) check_span();
    end
    spans_pending = expected_spans.size();
  end

endmodule

// File: verif/tb_top.sv
// testbench top: clock, reset, pixel and register stimulus, span receiver and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import brse_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int FULL_WIDTH     = 4096;
  localparam int WIDE_WIDTH     = 1200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  logic               wr_index = 1'b0;
  logic [CFG_W-1:0]   wr_data = '0;
  logic               pixel_valid = 1'b0;
  logic [BYTE_W-1:0]  pixel_byte = '0;
  logic               span_stall = 1'b0;
  logic               pixel_stall;
  logic               span_valid;
  logic [LEFT_W-1:0]  span_left;
  logic [RIGHT_W-1:0] span_right;
  logic [ROW_W-1:0]   span_row;
  logic               last_of_item;

  int mismatches;
  int spans_pending;
  int spans_checked;
  int bytes_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;
  bit dense_phase = 1'b0;

  always #5 clk = ~clk;

  bitmap_row_span_extractor_top #(
    .MAX_WIDTH (4096),
    .MAX_HEIGHT(4096)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_byte  (pixel_byte),
    .span_valid  (span_valid),
    .span_stall  (span_stall),
    .span_left   (span_left),
    .span_right  (span_right),
    .span_row    (span_row),
    .last_of_item(last_of_item)
  );

  brse_span_checker #(
    .MAX_WIDTH (4096),
    .MAX_HEIGHT(4096)
  ) span_check (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_byte   (pixel_byte),
    .span_valid   (span_valid),
    .span_stall   (span_stall),
    .span_left    (span_left),
    .span_right   (span_right),
    .span_row     (span_row),
    .last_of_item (last_of_item),
    .mismatches   (mismatches),
    .spans_pending(spans_pending),
    .spans_checked(spans_checked)
  );

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (span_valid && !span_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // span receiver: random stall segments, plus one long hold on request
  initial begin : span_receiver
    int seg;
    int kind;
    seg = 0;
    forever begin
      @(posedge clk);
      if (seg > 0) begin
        seg--;
      end else if (hold_request) begin
        span_stall <= 1'b1;
        seg = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          span_stall <= 1'b0;
          seg = $urandom_range(0, 4);
        end else if (kind < 70) begin
          span_stall <= 1'b0;
          seg = $urandom_range(20, 60);
        end else if (kind < 95) begin
          span_stall <= 1'b1;
          seg = $urandom_range(0, 2);
        end else begin
          span_stall <= 1'b1;
          seg = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (dense_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] random_pixel_byte();
    logic [BYTE_W-1:0] one_hot;
    one_hot = 8'h80 >> $urandom_range(0, 7);
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h55;
      3: return 8'hAA;
      4: return one_hot;
      5: return ~one_hot;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_width();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return CFG_W'(FULL_WIDTH);
    if (r < 12) return CFG_W'($urandom_range(1, 8));
    if (r < 18) return CFG_W'($urandom_range(9, 40));
    return CFG_W'($urandom_range(41, 300));
  endfunction

  function automatic logic [CFG_W-1:0] random_height();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return CFG_W'(1);
    return CFG_W'($urandom_range(2, 6));
  endfunction

  // called at a clock edge; leaves pixel_valid high after the transaction
  task automatic send_pixel(input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_byte  <= b;
    do @(posedge clk); while (pixel_stall);
    bytes_sent++;
  endtask

  // bytes with no span may still be in flight when the last span arrives
  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (spans_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wr_en    <= 1'b1;
    wr_index <= REG_IMAGE_WIDTH;
    wr_data  <= w;
    @(posedge clk);
    wr_index <= REG_IMAGE_HEIGHT;
    wr_data  <= h;
    @(posedge clk);
    wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] row_bytes[8];
    int n_items;
    row_bytes = '{8'h55, 8'h55, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h01};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry, then shrink the width to the current column
    send_pixel(8'hF0);
    send_pixel(8'h0F);
    drain();
    set_geometry(13'd16, 13'd3);
    send_pixel(8'hFF);
    // most spans per byte, full and empty rows, edge pixels, row wrap
    foreach (row_bytes[i]) send_pixel(row_bytes[i]);
    drain();
    set_geometry(13'd0, 13'd0);
    send_pixel(8'hFF);
    send_pixel(8'h7F);
    drain();
    set_geometry('1, '1);
    send_pixel(8'hAA);
    drain();
    set_geometry(13'd9, 13'd2);
    send_pixel(8'h80);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'h7F);

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      set_geometry(random_width(), random_height());
      dense_phase = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(20, 30);
      repeat (n_items) send_pixel(random_pixel_byte());
    end

    // long output hold with four spans per byte so the input backs up
    drain();
    set_geometry(13'd8, 13'd4);
    dense_phase = 1'b1;
    hold_request = 1'b1;
    while (hold_request) @(posedge clk);
    repeat (40) send_pixel($urandom_range(0, 1) ? 8'h55 : 8'hAA);

    // one long row, ending with a run open on its last column
    drain();
    set_geometry(CFG_W'(WIDE_WIDTH), 13'd2);
    dense_phase = 1'b0;
    repeat (WIDE_WIDTH / BYTE_W - 1) send_pixel(random_pixel_byte());
    send_pixel(8'h01);

    drain();
    $display("checked %0d spans from %0d pixel bytes over %0d width/height settings",
             spans_checked, bytes_sent, settings_used);
    $display("covered zero and oversized registers, mid-row changes, a long row"
             , " and a %0d-cycle output hold", HOLD_CYCLES);
    if (mismatches == 0 && spans_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: bitmap_row_span_extractor_top.f
sv/brse_pkg.sv
sv/brse_span_calc.sv
sv/bitmap_row_span_extractor_top.sv
sv/brse_checker.sv
verif/brse_span_checker.sv
verif/tb_top.sv
